### rtl/free_list_slot_table_core_macros.svh
// ----------------------------------------------------------------------------
// free_list_slot_table_core_macros
// Assertion macros used by the slot table core.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_SLOT_TABLE_CORE_MACROS_SVH
`define FREE_LIST_SLOT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FLS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot table check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define FLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot table check failed: next-cycle implication");

`endif

### rtl/fls_pkg.sv
// ----------------------------------------------------------------------------
// fls_pkg
// Beat types, codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package fls_pkg;

   // Table depth; slot fields are sized to index it.
   localparam int SLOTS     = 64;
   localparam int SLOT_BITS = 6;

   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_REMOVE  = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;
   localparam logic [1:0] ACT_NEXT    = 2'd3;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_FULL    = 2'd1;
   localparam logic [1:0] STS_END     = 2'd2;
   localparam logic [1:0] STS_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0]           action;
      logic [31:0]          position_x;
      logic [31:0]          position_y;
      logic [SLOT_BITS-1:0] slot_index;
   } fls_req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [SLOT_BITS-1:0] slot_out;
      logic [31:0]          payload_x;
      logic [31:0]          payload_y;
   } fls_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FETCH
   } fls_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan;
      logic fetch;
   } fls_cmd_type;

   typedef struct packed {
      logic req_is_scan;
      logic scan_end;
      logic scan_hit;
   } fls_status_type;

endpackage

### rtl/free_list_slot_table_core.sv
// ----------------------------------------------------------------------------
// free_list_slot_table_core
// Slot table with a LIFO free list threaded through freed slots.
// ----------------------------------------------------------------------------
// Add, remove and restart: start is taken in idle, the command runs in the execute
//   state and the result strobe is registered from it; busy until back in idle.
// Next occupied slot: the walk tests one free mark per cycle in the scan state, then
//   reads the payload and gives a hit from the fetch state, or gives the end result.
// Synchronous reset clears counters, free marks and the sequencer.
// Results cannot be stalled: each strobe lasts exactly one cycle.
module free_list_slot_table_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fls_pkg::fls_req_type req_data,
   output logic                 rsp_strobe,
   output fls_pkg::fls_rsp_type rsp_data
);
   import fls_pkg::*;

   `include "free_list_slot_table_core_macros.svh"

   fls_cmd_type    cmd;
   fls_status_type dp_status;

   fls_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (dp_status),
      .cmd    (cmd),
      .busy   (busy)
   );

   fls_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `FLS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `FLS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `FLS_ASSERT_NEXT(a_idle_no_strobe, clock, reset, !busy && !start, !rsp_strobe)
   `FLS_ASSERT_IMPLY(a_cmd_onehot, clock, reset, 1'b1,
                     $onehot0({cmd.capture, cmd.exec, cmd.scan, cmd.fetch}))

endmodule

### rtl/fls_ctrl.sv
// ----------------------------------------------------------------------------
// fls_ctrl
// Sequencer: an execute state for add/remove/restart, a slot walk for next.
// ----------------------------------------------------------------------------
module fls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  fls_pkg::fls_status_type status,
   output fls_pkg::fls_cmd_type   cmd,
   output logic                   busy
);
   import fls_pkg::*;

   fls_state_type state_ff;
   fls_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = status.req_is_scan ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            priority if (status.scan_end) begin
               state_in = ST_IDLE;
            end else if (status.scan_hit) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/fls_datapath.sv
// ----------------------------------------------------------------------------
// fls_datapath
// Slot memories, free marks, free-list head, counters and result register.
// ----------------------------------------------------------------------------
module fls_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  fls_pkg::fls_req_type    req_data,
   input  fls_pkg::fls_cmd_type    cmd,
   output fls_pkg::fls_status_type status,
   output logic                    rsp_strobe,
   output fls_pkg::fls_rsp_type    rsp_data
);
   import fls_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int XW = (CW > SLOT_BITS) ? CW : SLOT_BITS;

   // memories
   logic [63:0]   payload_mem_ff [SLOTS];
   logic [CW-1:0] link_mem_ff    [SLOTS];

   fls_req_type   req_ff;
   logic [CW-1:0] link_rd_ff;
   logic [63:0]   pay_rd_ff;

   logic [CW-1:0]    hw_ff,     hw_in;
   logic [CW-1:0]    head_ff,   head_in;
   logic [CW-1:0]    cursor_ff, cursor_in;
   logic [SLOTS-1:0] mark_ff,   mark_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fls_rsp_type      rsp_ff,    rsp_in;

   logic          full;
   logic          list_empty;
   logic [IW-1:0] add_slot;
   logic [XW-1:0] idx_ext;
   logic          rm_ok;
   logic          add_go;
   logic          rm_go;
   logic [CW-1:0] hit_slot;

   assign full       = (hw_ff == CW'(SLOTS));
   assign list_empty = (head_ff >= hw_ff);
   assign add_slot   = list_empty ? hw_ff[IW-1:0] : head_ff[IW-1:0];
   assign idx_ext    = XW'(req_ff.slot_index);
   assign rm_ok      = (idx_ext < XW'(hw_ff)) && !mark_ff[idx_ext[IW-1:0]];
   assign add_go     = cmd.exec && (req_ff.action == ACT_ADD) && !full;
   assign rm_go      = cmd.exec && (req_ff.action == ACT_REMOVE) && rm_ok;
   assign hit_slot   = cursor_ff - CW'(1);

   assign status.req_is_scan = (req_data.action == ACT_NEXT);
   assign status.scan_end    = (cursor_ff >= hw_ff);
   assign status.scan_hit    = (cursor_ff < hw_ff) && !mark_ff[cursor_ff[IW-1:0]];

   // memory ports: writes in execute, reads registered
   always_ff @(posedge clock) begin
      if (add_go) begin
         payload_mem_ff[add_slot] <= {req_ff.position_x, req_ff.position_y};
      end
      if (rm_go) begin
         link_mem_ff[idx_ext[IW-1:0]] <= head_ff;
      end
      if (cmd.capture) begin
         link_rd_ff <= link_mem_ff[head_ff[IW-1:0]];
      end
      if (cmd.scan) begin
         pay_rd_ff <= payload_mem_ff[cursor_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff        <= '0;
         head_ff      <= '0;
         cursor_ff    <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hw_ff        <= hw_in;
         head_ff      <= head_in;
         cursor_ff    <= cursor_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      hw_in        = hw_ff;
      head_in      = head_ff;
      cursor_in    = cursor_ff;
      mark_in      = mark_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      if (cmd.exec) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = STS_OK;
         unique case (req_ff.action)
            ACT_ADD: begin
               if (full) begin
                  rsp_in.status = STS_FULL;
               end else begin
                  rsp_in.slot_out   = SLOT_BITS'(add_slot);
                  mark_in[add_slot] = 1'b0;
                  if (list_empty) begin
                     hw_in   = hw_ff + CW'(1);
                     head_in = hw_ff + CW'(1);
                  end else begin
                     // pop: clamp a stale link to the high-water mark
                     head_in = (link_rd_ff > hw_ff) ? hw_ff : link_rd_ff;
                  end
               end
            end
            ACT_REMOVE: begin
               if (rm_ok) begin
                  mark_in[idx_ext[IW-1:0]] = 1'b1;
                  head_in                  = CW'(idx_ext);
               end else begin
                  rsp_in.status = STS_INVALID;
               end
            end
            ACT_RESTART: begin
               cursor_in = '0;
            end
            ACT_NEXT: begin
               rsp_in.status = STS_OK;
            end
         endcase
      end

      if (cmd.scan) begin
         if (status.scan_end) begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = STS_END;
         end else begin
            cursor_in = cursor_ff + CW'(1);
         end
      end

      if (cmd.fetch) begin
         rsp_valid_in     = 1'b1;
         rsp_in.status    = STS_OK;
         rsp_in.slot_out  = SLOT_BITS'(hit_slot);
         rsp_in.payload_x = pay_rd_ff[63:32];
         rsp_in.payload_y = pay_rd_ff[31:0];
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

### sim/free_list_slot_table_checker.sv
// ----------------------------------------------------------------------------
// free_list_slot_table_checker
// Watches the command and result channels of the slot table. Keeps its own
// copy of the table, free list, high-water count and scan cursor, predicts
// the result of every accepted command and compares each result beat with
// the oldest prediction.
// ----------------------------------------------------------------------------
module free_list_slot_table_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  fls_pkg::fls_req_type req_data,
   input  logic                 rsp_strobe,
   input  fls_pkg::fls_rsp_type rsp_data,
   output int                   error_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fls_pkg::*;

   // Counters must hold the value SLOTS itself.
   localparam int CNT_BITS = $clog2(SLOTS) + 1;

   logic [31:0]         slot_x [SLOTS];
   logic [31:0]         slot_y [SLOTS];
   logic [CNT_BITS-1:0] next_free [SLOTS];
   logic                is_free [SLOTS];
   logic [CNT_BITS-1:0] free_top;
   logic [CNT_BITS-1:0] used_count;
   logic [CNT_BITS-1:0] cursor;

   fls_rsp_type         due_results [$];
   int                  fails;

   function automatic fls_rsp_type apply_command(input fls_req_type beat);
      fls_rsp_type         res;
      logic [CNT_BITS-1:0] slot;
      logic                found;
      res = '0;
      found = 1'b0;
      case (beat.action)
         ACT_ADD: begin
            if (used_count >= SLOTS) begin
               res.status = STS_FULL;
            end else begin
               // Reuse the free list head, else grow into a fresh slot.
               slot = (free_top >= used_count) ? used_count : free_top;
               slot_x[slot] = beat.position_x;
               slot_y[slot] = beat.position_y;
               is_free[slot] = 1'b0;
               if (slot == used_count) begin
                  used_count = used_count + 1'b1;
                  free_top = used_count;
               end else begin
                  free_top = (next_free[slot] > used_count) ? used_count : next_free[slot];
               end
               res.status = STS_OK;
               res.slot_out = slot[SLOT_BITS-1:0];
            end
         end
         ACT_REMOVE: begin
            if (beat.slot_index >= used_count || is_free[beat.slot_index]) begin
               res.status = STS_INVALID;
            end else begin
               is_free[beat.slot_index] = 1'b1;
               next_free[beat.slot_index] = free_top;
               free_top = CNT_BITS'(beat.slot_index);
               res.status = STS_OK;
            end
         end
         ACT_RESTART: begin
            cursor = '0;
            res.status = STS_OK;
         end
         default: begin
            // Skip free slots; the cursor parks at the high-water count.
            while (!found && cursor < used_count) begin
               slot = cursor;
               cursor = cursor + 1'b1;
               if (!is_free[slot]) begin
                  found = 1'b1;
                  res.slot_out = slot[SLOT_BITS-1:0];
                  res.payload_x = slot_x[slot];
                  res.payload_y = slot_y[slot];
               end
            end
            res.status = found ? STS_OK : STS_END;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      fls_rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            is_free[i] = 1'b0;
         end
         free_top = '0;
         used_count = '0;
         cursor = '0;
         due_results.delete();
      end else begin
         // Retire the result beat before queuing a new prediction.
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("%t unexpected result beat: status %0d slot %0d x %h y %h",
                           $realtime, rsp_data.status, rsp_data.slot_out,
                           rsp_data.payload_x, rsp_data.payload_y);
               end
            end else begin
               want = due_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.slot_out !== want.slot_out ||
                   rsp_data.payload_x !== want.payload_x ||
                   rsp_data.payload_y !== want.payload_y) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%t result mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                              $realtime, want.status, rsp_data.status,
                              want.slot_out, rsp_data.slot_out);
                     $display("   x exp %h got %h, y exp %h got %h",
                              want.payload_x, rsp_data.payload_x,
                              want.payload_y, rsp_data.payload_y);
                  end
               end
            end
         end
         if (start && !busy) begin
            due_results.push_back(apply_command(req_data));
         end
      end
      error_count <= fails;
      pending_count <= due_results.size();
   end

endmodule

### sim/free_list_slot_table_core_tb.sv
// ----------------------------------------------------------------------------
// free_list_slot_table_core_tb
// Drives add, remove, restart and next-slot commands into the slot table:
// a directed opening, random bursts of fills, frees and scans with random
// idle gaps, then a fill to full, six removes, an add and a complete scan.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module free_list_slot_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fls_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   fls_req_type req_data;
   logic        rsp_strobe;
   fls_rsp_type rsp_data;
   int          error_count;
   int          pending_count;

   int          beat_count;
   int          used_guess;
   bit          idle_enabled;
   bit          mid_drained;

   always #2 clock = ~clock;

   free_list_slot_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   free_list_slot_table_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Mostly aim at slots that may be in use; now and then anywhere.
   function automatic logic [SLOT_BITS-1:0] pick_victim();
      if (used_guess == 0 || $urandom_range(0, 5) == 0) begin
         return SLOT_BITS'($urandom_range(0, SLOTS - 1));
      end
      return SLOT_BITS'($urandom_range(0, used_guess - 1));
   endfunction

   task automatic issue(input logic [1:0] action, input logic [31:0] px,
                        input logic [31:0] py, input logic [SLOT_BITS-1:0] idx);
      fls_req_type beat;
      beat.action = action;
      beat.position_x = px;
      beat.position_y = py;
      beat.slot_index = idx;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      beat_count++;
      if (action == ACT_ADD && used_guess < SLOTS) begin
         used_guess++;
      end
   endtask

   task automatic add_one();
      issue(ACT_ADD, rand_word(), rand_word(), SLOT_BITS'($urandom_range(0, SLOTS - 1)));
   endtask

   task automatic command_only(input logic [1:0] action);
      issue(action, $urandom(), $urandom(), SLOT_BITS'($urandom_range(0, SLOTS - 1)));
   endtask

   task automatic remove_slot(input logic [SLOT_BITS-1:0] idx);
      issue(ACT_REMOVE, $urandom(), $urandom(), idx);
   endtask

   // Hold off until every predicted result has been seen.
   task automatic wait_drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      beat_count = 0;
      used_guess = 0;
      idle_enabled = 1'b0;
      mid_drained = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed opening on an empty table.
      command_only(ACT_NEXT);
      remove_slot(6'd0);
      issue(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 6'd63);
      issue(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
      issue(ACT_ADD, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 6'd21);
      remove_slot(6'd1);
      remove_slot(6'd1);
      remove_slot(6'd3);
      remove_slot(6'd63);
      command_only(ACT_RESTART);
      repeat (4) command_only(ACT_NEXT);
      add_one();
      remove_slot(6'd0);
      remove_slot(6'd2);
      repeat (3) add_one();
      command_only(ACT_RESTART);
      command_only(ACT_NEXT);
      wait_drain();

      idle_enabled = 1'b1;
      while (beat_count < 480) begin
         if ($urandom_range(0, 5) == 0) begin
            idle_enabled = !idle_enabled;
         end
         if (beat_count >= 250 && !mid_drained) begin
            wait_drain();
            mid_drained = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 4)) add_one();
            3, 4, 5: repeat ($urandom_range(1, 4)) remove_slot(pick_victim());
            6, 7: begin
               command_only(ACT_RESTART);
               repeat ($urandom_range(1, used_guess + 2)) command_only(ACT_NEXT);
            end
            8: repeat (3) begin
               issue(2'($urandom_range(0, 3)), $urandom(), $urandom(),
                     SLOT_BITS'($urandom_range(0, SLOTS - 1)));
            end
            default: command_only(ACT_NEXT);
         endcase
      end

      // Fill to full, free some slots, then add against a non-empty free list.
      idle_enabled = 1'b0;
      repeat (SLOTS + 2) add_one();
      remove_slot(SLOT_BITS'(SLOTS - 1));
      remove_slot(SLOT_BITS'(SLOTS - 1));
      repeat (4) remove_slot(pick_victim());
      add_one();
      command_only(ACT_RESTART);
      repeat (SLOTS + 2) command_only(ACT_NEXT);

      wait_drain();
      repeat (SLOTS + 8) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/fls_pkg.sv
rtl/fls_ctrl.sv
rtl/fls_datapath.sv
rtl/free_list_slot_table_core.sv
sim/free_list_slot_table_checker.sv
sim/free_list_slot_table_core_tb.sv
